[rtl/tga_pkg.sv]
package tga_pkg;

	localparam int unsigned MAX_PIXELS = 65536;

	localparam logic [7:0] HDR_ID_LEN   = 8'd0;
	localparam logic [7:0] HDR_CMAP     = 8'd1;
	localparam logic [7:0] HDR_TYPE     = 8'd2;
	localparam logic [7:0] HDR_WIDTH_L  = 8'd12;
	localparam logic [7:0] HDR_WIDTH_H  = 8'd13;
	localparam logic [7:0] HDR_HEIGHT_L = 8'd14;
	localparam logic [7:0] HDR_HEIGHT_H = 8'd15;
	localparam logic [7:0] HDR_BPP      = 8'd16;
	localparam logic [7:0] HDR_LAST     = 8'd17;

	localparam logic [3:0] TYPE_NONE = 4'd0;
	localparam logic [3:0] TYPE_RAW  = 4'd2;
	localparam logic [3:0] TYPE_RLE  = 4'd10;

	localparam logic [7:0] BPP_24 = 8'd24;
	localparam logic [7:0] BPP_32 = 8'd32;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [16:0] EXPECTED_RESET = 17'h10000;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_BAD_TYPE = 3'd1;
	localparam logic [2:0] ERR_FORMAT   = 3'd2;
	localparam logic [2:0] ERR_COUNT    = 3'd3;
	localparam logic [2:0] ERR_NARROW   = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} tga_in_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] pixel_address;
		logic [7:0]  run_count;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [2:0]  error_code;
		logic        image_done;
		logic        last;
	} tga_out_t;

	typedef struct packed {
		logic hdr_byte;
		logic hdr_init;
		logic skip_byte;
		logic pkt_byte;
		logic pix_byte;
		logic seg_load;
		logic err_load;
	} tga_cmd_t;

	typedef struct packed {
		logic hdr_last;
		logic hdr_err;
		logic id_zero;
		logic is_rle;
		logic skip_done;
		logic pix_done;
		logic pkt_next;
		logic seg_last;
		logic seg_done;
		logic out_free;
	} tga_sts_t;

endpackage

[rtl/tga_dp.sv]
module tga_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata,
	input  tga_pkg::tga_in_t   byte_data,
	input  tga_pkg::tga_cmd_t  cmd,
	output tga_pkg::tga_sts_t  sts,
	output logic               result_valid,
	input  logic               result_ready,
	output tga_pkg::tga_out_t  result_data
);

	logic [16:0] expected_q;
	logic [7:0]  cnt_q;
	logic [7:0]  id_len_q;
	logic        cmap_q;
	logic [3:0]  kind_q;
	logic [7:0]  bpp_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] total_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [15:0] base_q;
	logic [7:0]  pkt_left_q;
	logic        pkt_run_q;
	logic [31:0] color_q;
	logic [1:0]  ci_q;
	logic [7:0]  n_q;
	logic        out_valid_q;
	tga_pkg::tga_out_t out_q;

	logic [7:0]  d;
	logic [7:0]  idx;
	logic [2:0]  err_code;
	logic        is_rle;
	logic [1:0]  ci_end;
	logic [15:0] room;
	logic [15:0] n_wide;
	logic        row_end;
	logic [7:0]  seg;

	assign d      = byte_data.data_byte;
	assign idx    = byte_data.first ? tga_pkg::HDR_ID_LEN : cnt_q;
	assign is_rle = (kind_q == tga_pkg::TYPE_RLE);
	assign ci_end = (bpp_q == tga_pkg::BPP_32) ? 2'd3 : 2'd2;
	assign room   = width_q - col_q;
	assign n_wide = {8'd0, n_q};
	assign row_end = (n_wide >= room);
	assign seg    = row_end ? room[7:0] : n_q;

	always_comb begin
		priority if (kind_q == tga_pkg::TYPE_NONE) begin
			err_code = tga_pkg::ERR_BAD_TYPE;
		end else if (cmap_q || (bpp_q != tga_pkg::BPP_24 && bpp_q != tga_pkg::BPP_32)) begin
			err_code = tga_pkg::ERR_FORMAT;
		end else if (total_q == 32'd0 || total_q != {15'd0, expected_q}
				|| total_q > 32'(tga_pkg::MAX_PIXELS)) begin
			err_code = tga_pkg::ERR_COUNT;
		end else if (width_q < 16'd4) begin
			err_code = tga_pkg::ERR_NARROW;
		end else begin
			err_code = tga_pkg::ERR_NONE;
		end
	end

	always_comb begin
		sts.hdr_last  = (idx == tga_pkg::HDR_LAST);
		sts.hdr_err   = (err_code != tga_pkg::ERR_NONE);
		sts.id_zero   = (id_len_q == 8'd0);
		sts.is_rle    = is_rle;
		sts.skip_done = (cnt_q == 8'd1);
		sts.pix_done  = (ci_q == ci_end);
		sts.pkt_next  = is_rle && (pkt_run_q || pkt_left_q == 8'd1);
		sts.seg_last  = (n_wide <= room) || (row_q == 16'd0);
		sts.seg_done  = row_end && (row_q == 16'd0);
		sts.out_free  = !out_valid_q || result_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= tga_pkg::EXPECTED_RESET;
			cnt_q      <= 8'd0;
			id_len_q   <= 8'd0;
			cmap_q     <= 1'b0;
			kind_q     <= tga_pkg::TYPE_NONE;
			bpp_q      <= 8'd0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			total_q    <= 32'd0;
			row_q      <= 16'd0;
			col_q      <= 16'd0;
			base_q     <= 16'd0;
			pkt_left_q <= 8'd0;
			pkt_run_q  <= 1'b0;
			color_q    <= 32'd0;
			ci_q       <= 2'd0;
			n_q        <= 8'd0;
			out_valid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			if (cfg_we) begin
				expected_q <= cfg_wdata;
			end
			total_q <= width_q * height_q;

			if (cmd.hdr_byte) begin
				unique case (idx)
					tga_pkg::HDR_ID_LEN:   id_len_q <= d;
					tga_pkg::HDR_CMAP:     cmap_q <= (d != 8'd0);
					tga_pkg::HDR_TYPE: begin
						if (d == {4'd0, tga_pkg::TYPE_RAW}) begin
							kind_q <= tga_pkg::TYPE_RAW;
						end else if (d == {4'd0, tga_pkg::TYPE_RLE}) begin
							kind_q <= tga_pkg::TYPE_RLE;
						end else begin
							kind_q <= tga_pkg::TYPE_NONE;
						end
					end
					tga_pkg::HDR_WIDTH_L:  width_q[7:0] <= d;
					tga_pkg::HDR_WIDTH_H:  width_q[15:8] <= d;
					tga_pkg::HDR_HEIGHT_L: height_q[7:0] <= d;
					tga_pkg::HDR_HEIGHT_H: height_q[15:8] <= d;
					tga_pkg::HDR_BPP:      bpp_q <= d;
					default: ;
				endcase
				cnt_q <= idx + 8'd1;
			end

			if (cmd.hdr_init) begin
				cnt_q      <= id_len_q;
				row_q      <= height_q - 16'd1;
				base_q     <= total_q[15:0] - width_q;
				col_q      <= 16'd0;
				ci_q       <= 2'd0;
				pkt_left_q <= 8'd0;
				pkt_run_q  <= 1'b0;
			end

			if (cmd.skip_byte) begin
				cnt_q <= cnt_q - 8'd1;
			end

			if (cmd.pkt_byte) begin
				pkt_left_q <= {1'b0, d[6:0]} + 8'd1;
				pkt_run_q  <= d[7];
				ci_q       <= 2'd0;
			end

			if (cmd.pix_byte) begin
				color_q[{ci_q, 3'b000} +: 8] <= d;
				if (sts.pix_done) begin
					ci_q <= 2'd0;
					if (bpp_q != tga_pkg::BPP_32) begin
						color_q[31:24] <= tga_pkg::ALPHA_OPAQUE;
					end
					if (is_rle && pkt_run_q) begin
						n_q        <= pkt_left_q;
						pkt_left_q <= 8'd0;
					end else begin
						n_q <= 8'd1;
						if (is_rle) begin
							pkt_left_q <= pkt_left_q - 8'd1;
						end
					end
				end else begin
					ci_q <= ci_q + 2'd1;
				end
			end

			if (cmd.seg_load) begin
				out_q.kind          <= tga_pkg::KIND_PIXEL;
				out_q.pixel_address <= base_q + col_q;
				out_q.run_count     <= seg;
				out_q.red           <= color_q[23:16];
				out_q.green         <= color_q[15:8];
				out_q.blue          <= color_q[7:0];
				out_q.alpha         <= color_q[31:24];
				out_q.error_code    <= tga_pkg::ERR_NONE;
				out_q.image_done    <= sts.seg_done;
				out_q.last          <= sts.seg_last;
				n_q <= n_q - seg;
				if (row_end) begin
					col_q <= 16'd0;
					if (row_q != 16'd0) begin
						row_q  <= row_q - 16'd1;
						base_q <= base_q - width_q;
					end
				end else begin
					col_q <= col_q + {8'd0, seg};
				end
			end else if (cmd.err_load) begin
				out_q            <= '0;
				out_q.kind       <= tga_pkg::KIND_ERROR;
				out_q.error_code <= err_code;
				out_q.last       <= 1'b1;
			end

			if (cmd.seg_load || cmd.err_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule

[rtl/tga_ctrl.sv]
module tga_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              first,
	output logic              byte_ready,
	input  tga_pkg::tga_sts_t sts,
	output tga_pkg::tga_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_HEADER = 6'b000001,
		ST_SKIP   = 6'b000010,
		ST_PACKET = 6'b000100,
		ST_PIXEL  = 6'b001000,
		ST_STOP   = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	state_t ph;
	logic   err_pend_q, err_pend_d;
	logic   fire;

	assign byte_ready = (state_q != ST_EMIT);
	assign fire = byte_valid && byte_ready;
	assign ph = first ? ST_HEADER : state_q;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		ret_d      = ret_q;
		err_pend_d = err_pend_q;
		if (fire) begin
			unique case (ph)
				ST_HEADER: begin
					cmd.hdr_byte = 1'b1;
					if (sts.hdr_last) begin
						if (sts.hdr_err) begin
							err_pend_d = 1'b1;
							state_d    = ST_EMIT;
						end else begin
							cmd.hdr_init = 1'b1;
							if (!sts.id_zero) begin
								state_d = ST_SKIP;
							end else begin
								state_d = sts.is_rle ? ST_PACKET : ST_PIXEL;
							end
						end
					end else begin
						state_d = ST_HEADER;
					end
				end
				ST_SKIP: begin
					cmd.skip_byte = 1'b1;
					if (sts.skip_done) begin
						state_d = sts.is_rle ? ST_PACKET : ST_PIXEL;
					end
				end
				ST_PACKET: begin
					cmd.pkt_byte = 1'b1;
					state_d = ST_PIXEL;
				end
				ST_PIXEL: begin
					cmd.pix_byte = 1'b1;
					if (sts.pix_done) begin
						ret_d   = sts.pkt_next ? ST_PACKET : ST_PIXEL;
						state_d = ST_EMIT;
					end
				end
				ST_STOP: state_d = ST_STOP;
				ST_EMIT: ;
				default: ;
			endcase
		end else if (state_q == ST_EMIT && sts.out_free) begin
			if (err_pend_q) begin
				cmd.err_load = 1'b1;
				err_pend_d   = 1'b0;
				state_d      = ST_STOP;
			end else begin
				cmd.seg_load = 1'b1;
				if (sts.seg_done) begin
					state_d = ST_STOP;
				end else if (sts.seg_last) begin
					state_d = ret_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_HEADER;
			ret_q      <= ST_HEADER;
			err_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			err_pend_q <= err_pend_d;
		end
	end

endmodule

[rtl/tga_rle_rgba_decoder_top.sv]
// tga image decoder: file bytes in, rgba run segments or one error report out
// byte channel: byte_valid/byte_ready carry one file byte and a first flag;
//   first restarts header parsing in any phase
// result channel: result_valid/result_ready carry one run segment or error,
//   held in an output register; last marks the final result of a byte
// cfg_we/cfg_wdata write the required pixel count (width times height)
// a byte that does not finish a pixel or the header loads no result
// a byte that finishes a pixel loads one result per row segment of its run,
//   one segment per cycle from the address adder unless the receiver stalls;
//   a header error loads one error report; when the receiver stalls,
//   segment generation in the emit state waits on the output register
//   and byte_ready stays low until all results of that byte are loaded
// reset: header parse at byte 0, pixel count register 65536, no result held
// after the final pixel or an error, bytes are taken and dropped until first
module tga_rle_rgba_decoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [16:0]       cfg_wdata,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  tga_pkg::tga_in_t  byte_data,
	output logic              result_valid,
	input  logic              result_ready,
	output tga_pkg::tga_out_t result_data
);

	tga_pkg::tga_cmd_t cmd;
	tga_pkg::tga_sts_t sts;

	tga_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.first      (byte_data.first),
		.byte_ready (byte_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tga_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.byte_data    (byte_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seg_load || cmd.err_load) |-> (!result_valid || result_ready))
		else $error("result register overwritten while held");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.hdr_byte, cmd.skip_byte, cmd.pkt_byte, cmd.pix_byte,
			cmd.seg_load, cmd.err_load}))
		else $error("more than one datapath action in a cycle");

	a_load_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seg_load || cmd.err_load) |-> !byte_ready)
		else $error("byte accepted while results are being produced");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.kind == tga_pkg::KIND_ERROR)
			|-> (result_data.last && result_data.run_count == 8'd0))
		else $error("malformed error report");
`endif

endmodule

[sim/tga_result_checker.sv]
`timescale 1ns / 1ps

module tga_result_checker
	import tga_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  tga_in_t     byte_data,
	input  logic        result_valid,
	input  logic        result_ready,
	input  tga_out_t    result_data,
	output int          fail_count,
	output int          pending
);

	localparam int MAX_SEGMENTS = 33;

	typedef enum logic [2:0] {HEADER, SKIP_ID, PACKET_HEAD, PIXEL_DATA, STOPPED} parse_phase_e;

	parse_phase_e phase;
	logic [16:0]  pixel_total;
	logic [7:0]   hdr_count;
	logic [15:0]  img_width;
	logic [15:0]  img_height;
	logic [3:0]   img_type;
	logic [7:0]   img_bpp;
	logic [15:0]  img_row;
	logic [15:0]  img_col;
	logic [7:0]   packet_left;
	logic         packet_is_run;
	logic [31:0]  img_color;
	logic [1:0]   comp;
	logic [7:0]   id_len;
	logic         has_cmap;

	tga_out_t segment_q[$];
	tga_out_t want;

	// split a run of the held color at row ends
	task automatic place_run(input int unsigned count);
		int unsigned room;
		int unsigned seg;
		int          made;
		logic [31:0] addr;
		tga_out_t    seg_out;
		made = 0;
		while (count > 0 && phase != STOPPED && made < MAX_SEGMENTS) begin
			room = img_width - img_col;
			seg = (count < room) ? count : room;
			addr = img_row * img_width + img_col;
			seg_out = '0;
			seg_out.kind = KIND_PIXEL;
			seg_out.pixel_address = addr[15:0];
			seg_out.run_count = seg[7:0];
			seg_out.red = img_color[23:16];
			seg_out.green = img_color[15:8];
			seg_out.blue = img_color[7:0];
			seg_out.alpha = img_color[31:24];
			seg_out.error_code = ERR_NONE;
			img_col = img_col + seg[15:0];
			count = count - seg;
			if (img_col >= img_width) begin
				img_col = '0;
				if (img_row == 0) begin
					seg_out.image_done = 1'b1;
					phase = STOPPED;
				end else begin
					img_row = img_row - 16'd1;
				end
			end
			segment_q.push_back(seg_out);
			made++;
		end
	endtask

	task automatic decode_byte(input tga_in_t req);
		logic [7:0]  d;
		logic [7:0]  idx;
		logic [31:0] total;
		logic [2:0]  err;
		tga_out_t    rpt;
		int          need;
		int unsigned run_len;
		int          base;
		d = req.data_byte;
		base = segment_q.size();
		if (req.first) begin
			phase = HEADER;
			hdr_count = '0;
		end
		case (phase)
		HEADER: begin
			idx = hdr_count;
			case (idx)
			HDR_ID_LEN: id_len = d;
			HDR_CMAP: has_cmap = (d != 8'd0);
			HDR_TYPE: begin
				if (d == {4'd0, TYPE_RAW})
					img_type = TYPE_RAW;
				else if (d == {4'd0, TYPE_RLE})
					img_type = TYPE_RLE;
				else
					img_type = TYPE_NONE;
			end
			HDR_WIDTH_L: img_width[7:0] = d;
			HDR_WIDTH_H: img_width[15:8] = d;
			HDR_HEIGHT_L: img_height[7:0] = d;
			HDR_HEIGHT_H: img_height[15:8] = d;
			HDR_BPP: img_bpp = d;
			default: ;
			endcase
			hdr_count = hdr_count + 8'd1;
			if (idx == HDR_LAST) begin
				total = img_width * img_height;
				err = ERR_NONE;
				if (img_type == TYPE_NONE)
					err = ERR_BAD_TYPE;
				else if (has_cmap || (img_bpp != BPP_24 && img_bpp != BPP_32))
					err = ERR_FORMAT;
				else if (total == 0 || total != pixel_total || total > MAX_PIXELS)
					err = ERR_COUNT;
				else if (img_width < 4)
					err = ERR_NARROW;
				if (err != ERR_NONE) begin
					rpt = '0;
					rpt.kind = KIND_ERROR;
					rpt.error_code = err;
					segment_q.push_back(rpt);
					phase = STOPPED;
				end else begin
					img_row = img_height - 16'd1;
					img_col = '0;
					comp = '0;
					packet_left = '0;
					packet_is_run = 1'b0;
					if (id_len != 0) begin
						hdr_count = id_len;
						phase = SKIP_ID;
					end else begin
						phase = (img_type == TYPE_RLE) ? PACKET_HEAD : PIXEL_DATA;
					end
				end
			end
		end
		SKIP_ID: begin
			hdr_count = hdr_count - 8'd1;
			if (hdr_count == 0)
				phase = (img_type == TYPE_RLE) ? PACKET_HEAD : PIXEL_DATA;
		end
		PACKET_HEAD: begin
			packet_left = {1'b0, d[6:0]} + 8'd1;
			packet_is_run = d[7];
			comp = '0;
			phase = PIXEL_DATA;
		end
		PIXEL_DATA: begin
			need = (img_bpp == BPP_32) ? 4 : 3;
			img_color[comp * 8 +: 8] = d;
			comp = comp + 2'd1;
			if (comp >= need || comp == 0) begin
				comp = '0;
				if (need == 3)
					img_color[31:24] = ALPHA_OPAQUE;
				if (img_type != TYPE_RLE) begin
					place_run(1);
				end else if (packet_is_run) begin
					run_len = packet_left;
					packet_left = '0;
					phase = PACKET_HEAD;
					place_run(run_len);
				end else begin
					packet_left = packet_left - 8'd1;
					if (packet_left == 0)
						phase = PACKET_HEAD;
					place_run(1);
				end
			end
		end
		default: ;
		endcase
		if (segment_q.size() > base) begin
			rpt = segment_q.pop_back();
			rpt.last = 1'b1;
			segment_q.push_back(rpt);
		end
	endtask

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total = EXPECTED_RESET;
			phase = HEADER;
			hdr_count = '0;
			img_width = '0;
			img_height = '0;
			img_type = TYPE_NONE;
			img_bpp = '0;
			img_row = '0;
			img_col = '0;
			packet_left = '0;
			packet_is_run = 1'b0;
			img_color = '0;
			comp = '0;
			id_len = '0;
			has_cmap = 1'b0;
			segment_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (segment_q.size() == 0) begin
					$display("%0t: result with no request waiting, expected none got %p",
						$time, result_data);
					fail_count++;
				end else begin
					want = segment_q.pop_front();
					check_field("kind", want.kind, result_data.kind);
					check_field("pixel_address", want.pixel_address, result_data.pixel_address);
					check_field("run_count", want.run_count, result_data.run_count);
					check_field("red", want.red, result_data.red);
					check_field("green", want.green, result_data.green);
					check_field("blue", want.blue, result_data.blue);
					check_field("alpha", want.alpha, result_data.alpha);
					check_field("error_code", want.error_code, result_data.error_code);
					check_field("image_done", want.image_done, result_data.image_done);
					check_field("last", want.last, result_data.last);
				end
			end
			if (cfg_we)
				pixel_total = cfg_wdata;
			if (byte_valid && byte_ready)
				decode_byte(byte_data);
			pending = segment_q.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import tga_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam logic [7:0] RAW_BYTE = {4'd0, TYPE_RAW};
	localparam logic [7:0] RLE_BYTE = {4'd0, TYPE_RLE};
	localparam int SIZE_COUNT = 9;
	localparam int SIZE_W[SIZE_COUNT] = '{4, 8, 5, 4, 6, 16, 4, 7, 12};
	localparam int SIZE_H[SIZE_COUNT] = '{4, 2, 4, 5, 3, 1, 8, 5, 3};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	tga_in_t     byte_data = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	tga_out_t    result_data;
	int          fail_count;
	int          pending;

	logic [7:0]  file_q[$];
	int unsigned pixel_cfg = EXPECTED_RESET;
	bit          burst = 1'b0;
	int unsigned cycle_count = 0;
	int          stall_left = 0;
	int          steady_left = 0;
	int          ready_roll;

	int          random_bytes;
	int          img_w;
	int          img_h;
	int          pick;
	int          form;
	int          idl;
	int          keep;
	int          fault;
	int          fw;
	int          fh;
	logic [7:0]  tbyte;
	logic [7:0]  cbyte;
	logic [7:0]  fbpp;
	logic [7:0]  img_kind;
	logic [7:0]  img_bpp;

	tga_rle_rgba_decoder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data)
	);

	tga_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver pacing: short stalls mostly, a few long ones, some stall-free stretches
	always @(posedge clk) begin
		if (steady_left > 0) begin
			steady_left--;
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			ready_roll = $urandom_range(99);
			if (ready_roll < 2) begin
				steady_left = $urandom_range(200, 50);
				result_ready <= 1'b1;
			end else if (ready_roll < 20) begin
				if (ready_roll < 16)
					stall_left = $urandom_range(2, 0);
				else if (ready_roll < 19)
					stall_left = $urandom_range(10, 3);
				else
					stall_left = $urandom_range(60, 20);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 8'h00;
		if (r < 30)
			return 8'hff;
		return 8'($urandom);
	endfunction

	function automatic int pick_packet_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(4, 1);
		if (r < 85)
			return $urandom_range(16, 5);
		if (r < 95)
			return $urandom_range(127, 17);
		return 128;
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic first);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{value, first};
		do @(posedge clk); while (!byte_ready);
	endtask

	task automatic send_file(input int count);
		for (int i = 0; i < count; i++)
			send_byte(file_q[i], i == 0);
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic wait_idle();
		byte_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_pixel_total(input int unsigned value);
		cfg_we <= 1'b1;
		cfg_wdata <= 17'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		pixel_cfg = value;
	endtask

	task automatic push_header(input int id_count, input logic [7:0] cmap,
			input logic [7:0] kind_byte, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] bpp);
		file_q.delete();
		repeat (18) file_q.push_back(8'($urandom));
		file_q[HDR_ID_LEN] = 8'(id_count);
		file_q[HDR_CMAP] = cmap;
		file_q[HDR_TYPE] = kind_byte;
		file_q[HDR_WIDTH_L] = w[7:0];
		file_q[HDR_WIDTH_H] = w[15:8];
		file_q[HDR_HEIGHT_L] = h[7:0];
		file_q[HDR_HEIGHT_H] = h[15:8];
		file_q[HDR_BPP] = bpp;
		repeat (id_count) file_q.push_back(8'($urandom));
	endtask

	task automatic push_pixel(input logic [7:0] bpp);
		repeat ((bpp == BPP_32) ? 4 : 3) file_q.push_back(pick_byte());
	endtask

	task automatic build_image(input int id_count, input logic [7:0] kind_byte, input int w,
			input int h, input logic [7:0] bpp);
		int   left;
		int   n;
		logic run;
		push_header(id_count, 8'd0, kind_byte, 16'(w), 16'(h), bpp);
		left = w * h;
		while (left > 0) begin
			if (kind_byte == RLE_BYTE) begin
				n = pick_packet_len();
				run = 1'($urandom_range(1));
				file_q.push_back({run, 7'(n - 1)});
				if (run)
					push_pixel(bpp);
				else
					repeat (n) push_pixel(bpp);
			end else begin
				n = 1;
				push_pixel(bpp);
			end
			left -= n;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// header checks under the reset pixel total, priority order included
		push_header(0, 8'd1, 8'd1, 16'd4, 16'd4, BPP_24);
		send_file(file_q.size());
		push_header(5, 8'd1, RAW_BYTE, 16'd256, 16'd256, BPP_24);
		send_file(file_q.size());
		send_noise(4);
		push_header(0, 8'd0, RLE_BYTE, 16'd3, 16'd5, 8'd16);
		send_file(file_q.size());
		push_header(0, 8'd0, RAW_BYTE, 16'd2, 16'd100, BPP_32);
		send_file(file_q.size());
		push_header(0, 8'd0, RAW_BYTE, 16'd0, 16'd0, BPP_24);
		send_file(file_q.size());
		push_header(0, 8'd0, RLE_BYTE, 16'd2, 16'd32768, BPP_32);
		send_file(file_q.size());
		push_header(0, 8'd0, RAW_BYTE, 16'd255, 16'd255, BPP_24);
		send_file(file_q.size());

		wait_idle();
		write_pixel_total(16);
		build_image(3, RAW_BYTE, 4, 4, BPP_24);
		send_file(file_q.size());
		send_noise(3);
		push_header(0, 8'd0, RLE_BYTE, 16'd16, 16'd1, BPP_32);
		file_q.push_back(8'h8f);
		push_pixel(BPP_32);
		send_file(file_q.size());
		send_noise(2);
		// restart in the middle of a file
		build_image(0, RLE_BYTE, 16, 1, BPP_32);
		send_file(file_q.size() / 2);
		build_image(0, RLE_BYTE, 8, 2, BPP_24);
		send_file(file_q.size());

		// one run crossing many short rows from a nonzero column
		wait_idle();
		write_pixel_total(160);
		push_header(0, 8'd0, RLE_BYTE, 16'd4, 16'd40, BPP_24);
		file_q.push_back(8'h00);
		push_pixel(BPP_24);
		file_q.push_back(8'hff);
		push_pixel(BPP_24);
		file_q.push_back(8'h9e);
		push_pixel(BPP_24);
		send_file(file_q.size());

		random_bytes = 0;
		while (random_bytes < 60) begin
			if (random_bytes == 0 || $urandom_range(2) == 0) begin
				pick = $urandom_range(SIZE_COUNT - 1);
				img_w = SIZE_W[pick];
				img_h = SIZE_H[pick];
				wait_idle();
				write_pixel_total(img_w * img_h);
			end
			burst = ($urandom_range(3) == 0);
			form = $urandom_range(99);
			pick = $urandom_range(99);
			idl = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(6, 1) : $urandom_range(40, 7);
			img_kind = $urandom_range(1) ? RLE_BYTE : RAW_BYTE;
			img_bpp = $urandom_range(1) ? BPP_32 : BPP_24;
			if (form < 65) begin
				build_image(idl, img_kind, img_w, img_h, img_bpp);
				send_file(file_q.size());
				random_bytes += file_q.size();
				if ($urandom_range(3) == 0)
					send_noise($urandom_range(4, 1));
			end else if (form < 78) begin
				build_image(idl, img_kind, img_w, img_h, img_bpp);
				keep = $urandom_range(file_q.size() - 1, 1);
				send_file(keep);
				random_bytes += keep;
			end else if (form < 92) begin
				tbyte = img_kind;
				cbyte = 8'd0;
				fbpp = img_bpp;
				fw = img_w;
				fh = img_h;
				fault = $urandom_range(4);
				case (fault)
				0: do tbyte = 8'($urandom); while (tbyte == RAW_BYTE || tbyte == RLE_BYTE);
				1: cbyte = 8'($urandom_range(255, 1));
				2: do fbpp = 8'($urandom); while (fbpp == BPP_24 || fbpp == BPP_32);
				3: fh = img_h + 1;
				default: begin
					fw = $urandom_range(3, 1);
					fh = pixel_cfg / fw;
					if (fw * fh != pixel_cfg) begin
						fw = 1;
						fh = pixel_cfg;
					end
				end
				endcase
				push_header(idl, cbyte, tbyte, 16'(fw), 16'(fh), fbpp);
				send_file(file_q.size());
				random_bytes += 18;
			end else begin
				send_noise($urandom_range(8, 2));
			end
			if ($urandom_range(9) == 0)
				wait_idle();
		end
		burst = 1'b0;

		wait_idle();
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[tga_rle_rgba_decoder_top.f]
rtl/tga_pkg.sv
rtl/tga_dp.sv
rtl/tga_ctrl.sv
rtl/tga_rle_rgba_decoder_top.sv
sim/tga_result_checker.sv
sim/tb_top.sv
